// ===== hw/rtl/hjoc_pkg.sv =====
// hjoc_pkg: constants shared by the http json object capture unit
// character codes, parse phase codes, field widths and register indexes
// no dependencies
`default_nettype none

package hjoc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 12;
    localparam int unsigned WAIT_W    = 16;
    localparam int unsigned LIMIT_W   = 13;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [BYTE_W-1:0] CH_H      = 8'h48;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h54;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7b;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7d;

    localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_T1      = 3'd1;
    localparam logic [PHASE_W-1:0] PH_T2      = 3'd2;
    localparam logic [PHASE_W-1:0] PH_P       = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SLASH   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_CAPTURE = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_BRACE_WAIT_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LIMIT    = 1'd1;

    localparam logic [WAIT_W-1:0]  BRACE_WAIT_RESET = 16'd255;
    localparam logic [LIMIT_W-1:0] CAPTURE_RESET    = 13'd256;
    localparam logic [LIMIT_W-1:0] CAPTURE_MAX      = 13'd4096;
    localparam logic [WAIT_W-1:0]  WAIT_SAT         = 16'hffff;

endpackage

`default_nettype wire

// ===== hw/rtl/http_json_object_capture_unit.sv =====
// http_json_object_capture_unit: top level, byte-serial header hunt and json object capture
// depends on hjoc_pkg
//
// channel   | direction | handshake                  | payload
// rx        | in        | i_in_valid / o_in_stall    | i_rx_byte
// result    | out       | o_out_valid / i_out_stall  | o_captured_byte, o_capture_valid,
//           |           |                            | o_position, o_object_end,
//           |           |                            | o_object_dropped, o_brace_timeout
// config    | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// one byte per cycle while the input is not stalled; the result appears in the cycle after the byte transaction
// the phase compare and the two counters are combinational, ahead of the result register
// input stalls only while a held result is itself stalled
// synchronous active-low reset returns to the header hunt with default limits
`default_nettype none

module http_json_object_capture_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [hjoc_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [hjoc_pkg::BYTE_W-1:0]       o_captured_byte,
    output logic                                   o_capture_valid,
    output logic      [hjoc_pkg::POS_W-1:0]        o_position,
    output logic                                   o_object_end,
    output logic                                   o_object_dropped,
    output logic                                   o_brace_timeout,
    input  wire logic                              i_cfg_we,
    input  wire logic [hjoc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [hjoc_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    logic [hjoc_pkg::WAIT_W-1:0]  r_brace_wait_limit;
    logic [hjoc_pkg::LIMIT_W-1:0] r_capture_limit;
    logic [hjoc_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [hjoc_pkg::POS_W-1:0]   r_capture_count, n_capture_count;
    logic [hjoc_pkg::WAIT_W-1:0]  r_wait_count, n_wait_count;

    logic                         r_out_valid;
    logic [hjoc_pkg::BYTE_W-1:0]  r_byte, n_byte;
    logic                         r_cvalid, n_cvalid;
    logic [hjoc_pkg::POS_W-1:0]   r_pos, n_pos;
    logic                         r_end, n_end;
    logic                         r_drop, n_drop;
    logic                         r_tmo, n_tmo;

    logic                         in_accept;
    logic [hjoc_pkg::LIMIT_W-1:0] lim;
    logic [hjoc_pkg::LIMIT_W-1:0] count_inc;
    logic                         at_limit;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // limit clamp; a limit of 0 or 1 makes at_limit true on every byte
    assign lim       = (r_capture_limit > hjoc_pkg::CAPTURE_MAX) ?
                       hjoc_pkg::CAPTURE_MAX : r_capture_limit;
    assign count_inc = {1'b0, r_capture_count} + 13'd1;
    assign at_limit  = count_inc >= lim;

    always_comb begin
        n_phase         = r_phase;
        n_capture_count = r_capture_count;
        n_wait_count    = r_wait_count;
        n_byte          = '0;
        n_cvalid        = 1'b0;
        n_pos           = '0;
        n_end           = 1'b0;
        n_drop          = 1'b0;
        n_tmo           = 1'b0;
        unique case (r_phase)
            hjoc_pkg::PH_HUNT: begin
                if (i_rx_byte == hjoc_pkg::CH_H) n_phase = hjoc_pkg::PH_T1;
            end
            hjoc_pkg::PH_T1: begin
                n_phase = (i_rx_byte == hjoc_pkg::CH_T) ? hjoc_pkg::PH_T2 : hjoc_pkg::PH_HUNT;
            end
            hjoc_pkg::PH_T2: begin
                n_phase = (i_rx_byte == hjoc_pkg::CH_T) ? hjoc_pkg::PH_P : hjoc_pkg::PH_HUNT;
            end
            hjoc_pkg::PH_P: begin
                n_phase = (i_rx_byte == hjoc_pkg::CH_P) ? hjoc_pkg::PH_SLASH : hjoc_pkg::PH_HUNT;
            end
            hjoc_pkg::PH_SLASH: begin
                n_phase = (i_rx_byte == hjoc_pkg::CH_SLASH) ? hjoc_pkg::PH_WAIT :
                                                              hjoc_pkg::PH_HUNT;
            end
            hjoc_pkg::PH_WAIT: begin
                priority if (i_rx_byte == hjoc_pkg::CH_LBRACE) begin
                    n_phase         = hjoc_pkg::PH_CAPTURE;
                    n_byte          = i_rx_byte;
                    n_cvalid        = 1'b1;
                    n_capture_count = 12'd1;
                    n_wait_count    = '0;
                end else if (r_wait_count > r_brace_wait_limit) begin
                    n_phase      = hjoc_pkg::PH_HUNT;
                    n_wait_count = '0;
                    n_tmo        = 1'b1;
                end else if (r_wait_count != hjoc_pkg::WAIT_SAT) begin
                    n_wait_count = r_wait_count + 16'd1;
                end else begin
                    n_wait_count = r_wait_count;
                end
            end
            hjoc_pkg::PH_CAPTURE: begin
                if (at_limit) begin
                    n_capture_count = '0;
                    n_phase         = hjoc_pkg::PH_HUNT;
                    n_drop          = 1'b1;
                end else begin
                    n_byte          = i_rx_byte;
                    n_cvalid        = 1'b1;
                    n_pos           = r_capture_count;
                    n_capture_count = count_inc[hjoc_pkg::POS_W-1:0];
                    if (i_rx_byte == hjoc_pkg::CH_RBRACE) begin
                        n_phase         = hjoc_pkg::PH_HUNT;
                        n_capture_count = '0;
                        n_end           = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = hjoc_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brace_wait_limit <= hjoc_pkg::BRACE_WAIT_RESET;
            r_capture_limit    <= hjoc_pkg::CAPTURE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hjoc_pkg::REG_BRACE_WAIT_LIMIT: r_brace_wait_limit <= i_cfg_data;
                hjoc_pkg::REG_CAPTURE_LIMIT:
                    r_capture_limit <= i_cfg_data[hjoc_pkg::LIMIT_W-1:0];
                default: r_capture_limit <= r_capture_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= hjoc_pkg::PH_HUNT;
            r_capture_count <= '0;
            r_wait_count    <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase         <= n_phase;
                r_capture_count <= n_capture_count;
                r_wait_count    <= n_wait_count;
                r_out_valid     <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte   <= n_byte;
            r_cvalid <= n_cvalid;
            r_pos    <= n_pos;
            r_end    <= n_end;
            r_drop   <= n_drop;
            r_tmo    <= n_tmo;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_captured_byte  = r_byte;
    assign o_capture_valid  = r_cvalid;
    assign o_position       = r_pos;
    assign o_object_end     = r_end;
    assign o_object_dropped = r_drop;
    assign o_brace_timeout  = r_tmo;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_end, r_drop, r_tmo}))
        else $error("more than one terminating flag in one result");

    a_end_is_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_end |-> r_cvalid && (r_byte == hjoc_pkg::CH_RBRACE))
        else $error("object end without captured closing brace");

    a_terminate_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (n_end || n_drop || n_tmo) |=> r_phase == hjoc_pkg::PH_HUNT)
        else $error("phase not back to hunt after object terminated");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != hjoc_pkg::PH_CAPTURE |-> r_capture_count == '0)
        else $error("capture count nonzero outside capture");

    a_wait_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != hjoc_pkg::PH_WAIT |-> r_wait_count == '0)
        else $error("wait count nonzero outside brace wait");

endmodule

`default_nettype wire
